### sv/apse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Annex B parameter set extractor package
// Shared constants, scan modes, result codes and the result push bundle.
// ----------------------------------------------------------------------------
package apse_pkg;

	localparam int SCAN_LIMIT_DEF = 256;
	localparam int FIFO_DEPTH = 4;

	localparam logic [1:0] KIND_SPS = 2'd0;
	localparam logic [1:0] KIND_PPS = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	localparam logic [4:0] NAL_SPS = 5'd7;
	localparam logic [4:0] NAL_PPS = 5'd8;

	localparam logic [2:0] HOLD_LONG = 3'd4;
	localparam logic [2:0] HOLD_SHORT = 3'd3;

	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_SPS = 2'd1,
		MODE_PPS = 2'd2,
		MODE_STOP = 2'd3
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t a;
		result_t b;
	} push_t;

endpackage
`default_nettype wire

### sv/annexb_parameter_set_extractor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Annex B parameter set extractor
// Scans packet bytes for start codes and passes on SPS and PPS units.
// ----------------------------------------------------------------------------
// The input channel takes one packet byte per request, with last_byte set on
// the final byte of the packet. The output channel returns extracted bytes
// tagged as SPS or PPS, and one end marker after each packet's last byte.
// Each byte is decided when the byte four places later arrives, so the
// output trails the input stream by four bytes; the final four bytes of a
// packet are never emitted. A decided result is written to the result queue
// when its request is accepted and is shown once the results ahead drain.
// The scanner takes one request per clock while in_ready is high. Each
// request yields at most one data byte plus, on the last byte, an end
// marker, and both go into a four-entry result queue that drains one result
// per clock while out_ready is high. in_ready is high while the queue has
// room for two results. With a receiver that keeps up the queue never holds
// more than two, so the input runs at one byte per clock with no bubbles,
// end markers included. When the receiver stalls, the queue fills and
// in_ready drops. Reset clears the scan state and empties the queue; the
// block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module annexb_parameter_set_extractor
	import apse_pkg::*;
#(
	parameter int SCAN_LIMIT = SCAN_LIMIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] in_byte,
	input wire logic last_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] kind
);

	logic accept;
	push_t push;

	assign accept = in_valid && in_ready;

	apse_scan #(
		.SCAN_LIMIT(SCAN_LIMIT)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_byte(in_byte),
		.last_byte(last_byte),
		.push(push)
	);

	apse_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.kind(kind)
	);

endmodule
`default_nettype wire

### sv/apse_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Start code scanner
// Holds the five-byte window and scan state, decides the oldest window
// position for each accepted request and bundles up to two results.
// ----------------------------------------------------------------------------
module apse_scan
	import apse_pkg::*;
#(
	parameter int SCAN_LIMIT = SCAN_LIMIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [7:0] in_byte,
	input wire logic last_byte,
	output push_t push
);

	localparam int IW = $clog2(SCAN_LIMIT + 1);

	logic [39:0] window_q;
	logic [IW-1:0] index_q;
	scan_mode_t mode_q;
	logic [2:0] hold_q;

	logic [39:0] window_n;
	logic in_range;
	logic decide_en;
	logic four_hit;
	logic three_hit;
	logic [4:0] unit_type;
	scan_mode_t mode_d;
	logic [2:0] hold_d;
	logic emit;
	result_t data_res;
	result_t end_res;

	assign window_n = {window_q[31:0], in_byte};
	assign in_range = index_q < IW'(SCAN_LIMIT);
	assign decide_en = in_range && (index_q >= IW'(4));
	assign four_hit = window_n[39:8] == 32'h0000_0001;
	assign three_hit = window_n[39:16] == 24'h00_0001;
	assign unit_type = four_hit ? window_n[4:0] : window_n[12:8];

	always_comb begin
		mode_d = mode_q;
		hold_d = hold_q;
		emit = 1'b0;
		if (decide_en && mode_q != MODE_STOP) begin
			if (mode_q != MODE_SEARCH && hold_q != 3'd0) begin
				emit = 1'b1;
				hold_d = hold_q - 3'd1;
			end else if (four_hit || three_hit) begin
				if (unit_type == NAL_SPS || unit_type == NAL_PPS) begin
					mode_d = (unit_type == NAL_SPS) ? MODE_SPS : MODE_PPS;
					hold_d = four_hit ? HOLD_LONG : HOLD_SHORT;
					emit = 1'b1;
				end else begin
					mode_d = MODE_STOP;
					hold_d = 3'd0;
				end
			end else if (mode_q != MODE_SEARCH) begin
				emit = 1'b1;
			end
		end
	end

	always_comb begin
		data_res.data = window_n[39:32];
		data_res.kind = (mode_d == MODE_SPS) ? KIND_SPS : KIND_PPS;
		end_res.data = 8'd0;
		end_res.kind = KIND_END;
		push.n = 2'd0;
		push.a = emit ? data_res : end_res;
		push.b = end_res;
		if (accept) begin
			push.n = {1'b0, emit} + {1'b0, last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			index_q <= '0;
			mode_q <= MODE_SEARCH;
			hold_q <= 3'd0;
		end else if (accept) begin
			if (last_byte) begin
				window_q <= '0;
				index_q <= '0;
				mode_q <= MODE_SEARCH;
				hold_q <= 3'd0;
			end else if (in_range) begin
				window_q <= window_n;
				index_q <= index_q + IW'(1);
				mode_q <= mode_d;
				hold_q <= hold_d;
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> index_q == '0 && mode_q == MODE_SEARCH && hold_q == 3'd0)
		else $error("scan state not cleared after the last byte");

	a_stop_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_STOP |-> hold_q == 3'd0)
		else $error("hold count left pending in stopped mode");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		index_q <= IW'(SCAN_LIMIT) && hold_q <= HOLD_LONG)
		else $error("byte index or hold count out of range");

	a_search_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_byte && mode_q == MODE_SEARCH && mode_d == MODE_SEARCH
		|-> push.n == 2'd0)
		else $error("byte emitted while searching");

endmodule
`default_nettype wire

### sv/apse_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results per cycle and hands
// one result per cycle to the output channel while out_ready is high.
// ----------------------------------------------------------------------------
module apse_out_fifo
	import apse_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire push_t push,
	output logic room,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] kind
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	result_t mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic pop;

	assign out_valid = count_q != '0;
	assign pop = out_valid && out_ready;
	assign room = count_q <= CW'(FIFO_DEPTH - 2);
	assign out_byte = mem_q[rd_ptr_q].data;
	assign kind = mem_q[rd_ptr_q].kind;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.a;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + PW'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(push.n) <= CW'(FIFO_DEPTH) - count_q)
		else $error("result queue overflow");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		##1 $past(arst_n) |-> count_q ==
		$past(count_q) + CW'($past(push.n)) - CW'($past(pop)))
		else $error("result queue count mismatch");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(FIFO_DEPTH))
		else $error("result queue count out of range");

endmodule
`default_nettype wire
